// ----- sv/nvrc_pkg.sv -----
// ----------------------------------------------------------------------------
// nvrc_pkg
// Shared types and constants of the n-gram varint record checker.
// ----------------------------------------------------------------------------
`default_nettype none

package nvrc_pkg;

    localparam int unsigned MAX_TOKENS = 7;

    localparam int unsigned IN_DATA_W   = 8;
    localparam int unsigned OUT_DATA_W  = 40;
    localparam int unsigned OUT_USER_W  = 4;
    localparam int unsigned CFG_ADDR_W  = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [6:0] GROUP_MASK = 7'h7F;

    typedef enum logic [1:0] {
        PH_FREQ  = 2'd0,
        PH_TOKEN = 2'd1,
        PH_HALT  = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        EV_MID           = 4'd0,
        EV_FREQ_DONE     = 4'd1,
        EV_TOKEN_DONE    = 4'd2,
        EV_RECORD_DONE   = 4'd3,
        EV_GROUP_END     = 4'd4,
        EV_ALL_GROUPS    = 4'd5,
        EV_CLEAN_END     = 4'd6,
        EV_FREQ_RANGE    = 4'd7,
        EV_UNKNOWN_TOKEN = 4'd8,
        EV_TRUNCATED     = 4'd9,
        EV_EXTRA_BYTES   = 4'd10,
        EV_HALTED        = 4'd11
    } evt_t;

    typedef enum logic [1:0] {
        REG_TOKENS   = 2'd0,
        REG_VOCAB    = 2'd1,
        REG_MAX_FREQ = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [2:0]  tokens_per_ngram;
        logic [31:0] vocab_size;
        logic [14:0] max_freq;
    } cfg_t;

    typedef struct packed {
        evt_t        event_res;
        logic [31:0] field_value;
        logic [7:0]  byte_echo;
    } result_t;

endpackage

`default_nettype wire

// ----- sv/ngram_varint_record_checker.sv -----
// ----------------------------------------------------------------------------
// ngram_varint_record_checker
// Checks a byte stream of varint-coded n-gram records and vocabulary groups.
// ----------------------------------------------------------------------------
// One item per clock cycle while the output is not stalled; an input register
// feeds the combinational decode update in nvrc_core, and its result lands in
// the output register, which holds it while the output is stalled, and such a
// stall also holds the input side. Each input item gives exactly one result
// item. After a clean end or any error every later item answers "halted"
// until reset. Configuration writes take effect on the next cycle.
`default_nettype none

module ngram_varint_record_checker #(
    parameter int TOKEN_BITS = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [nvrc_pkg::IN_DATA_W-1:0]       s_tdata,   // [7:0] byte_value
    input  wire logic                                 s_tuser,   // [0] req_type
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [nvrc_pkg::OUT_DATA_W-1:0]           m_tdata,   // [31:0] field_value,
                                                                 // [39:32] byte_echo
    output logic [nvrc_pkg::OUT_USER_W-1:0]           m_tuser,   // [3:0] event_res
    input  wire logic                                 cfg_we,
    input  wire logic [nvrc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [nvrc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import nvrc_pkg::*;

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic        in_end_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    result_t     result;
    logic        advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tokens_per_ngram <= 3'd1;
            cfg_reg.vocab_size       <= 32'd0;
            cfg_reg.max_freq         <= 15'h7FFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_TOKENS:   cfg_reg.tokens_per_ngram <= cfg_data[2:0];
                REG_VOCAB:    cfg_reg.vocab_size       <= cfg_data[31:0];
                REG_MAX_FREQ: cfg_reg.max_freq         <= cfg_data[14:0];
                default:      cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_end_reg  <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    nvrc_core #(
        .TOKEN_BITS (TOKEN_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .end_in  (in_end_reg),
        .byte_in (in_byte_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_res;
    assign m_tdata  = {out_reg.byte_echo, out_reg.field_value};

endmodule

`default_nettype wire

// ----- sv/nvrc_core.sv -----
// ----------------------------------------------------------------------------
// nvrc_core
// Record decode state and the combinational update for one stream item.
// ----------------------------------------------------------------------------
`default_nettype none

module nvrc_core #(
    parameter int TOKEN_BITS = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic             end_in,
    input  wire logic [7:0]       byte_in,
    input  wire nvrc_pkg::cfg_t   cfg,
    output nvrc_pkg::result_t     result
);
    import nvrc_pkg::*;

    localparam int AW = (TOKEN_BITS > 15) ? TOKEN_BITS : 15;
    localparam int NW = AW + 7;
    localparam int CW = (NW > 32) ? NW : 32;

    phase_t        phase_reg,       phase_next;
    logic [AW-1:0] acc_reg,         acc_next;
    logic [2:0]    tokens_reg,      tokens_next;
    logic [31:0]   groups_reg,      groups_next;
    logic          in_record_reg,   in_record_next;

    logic [NW-1:0] nxt;
    logic          groups_done;
    logic          extra;
    logic          freq_over;
    logic          tok_over;
    logic          cont;
    logic          nxt_zero;
    logic [2:0]    tokens_inc;
    logic [2:0]    eff_count;
    logic [31:0]   groups_inc;
    logic          rec_done;

    assign nxt         = {acc_reg, 7'b0} + NW'(byte_in[6:0] & GROUP_MASK);
    assign groups_done = (groups_reg >= cfg.vocab_size);
    assign extra       = (phase_reg == PH_FREQ) && !in_record_reg && groups_done;
    assign freq_over   = (nxt > NW'(cfg.max_freq));
    assign tok_over    = (CW'(nxt) >= CW'(cfg.vocab_size))
                         || (nxt[NW-1:TOKEN_BITS] != '0);
    assign cont        = byte_in[7];
    assign nxt_zero    = (nxt == '0);
    assign tokens_inc  = tokens_reg + 3'd1;
    assign groups_inc  = groups_reg + 32'd1;
    assign eff_count   = (cfg.tokens_per_ngram == 3'd0) ? 3'd1 :
                         (32'(cfg.tokens_per_ngram) > MAX_TOKENS) ? 3'(MAX_TOKENS) :
                         cfg.tokens_per_ngram;
    assign rec_done    = (tokens_inc >= eff_count);

    always_comb
    begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        tokens_next    = tokens_reg;
        groups_next    = groups_reg;
        in_record_next = in_record_reg;
        unique case (phase_reg)
            PH_FREQ:
            begin
                priority if (end_in || extra || freq_over)
                begin
                    phase_next = PH_HALT;
                end
                else if (cont)
                begin
                    acc_next       = AW'(nxt);
                    in_record_next = 1'b1;
                end
                else if (nxt_zero)
                begin
                    acc_next       = '0;
                    in_record_next = 1'b0;
                    groups_next    = groups_inc;
                end
                else
                begin
                    acc_next       = '0;
                    phase_next     = PH_TOKEN;
                    tokens_next    = 3'd0;
                    in_record_next = 1'b1;
                end
            end
            PH_TOKEN:
            begin
                priority if (end_in || tok_over)
                begin
                    phase_next = PH_HALT;
                end
                else if (cont)
                begin
                    acc_next = AW'(nxt);
                end
                else if (rec_done)
                begin
                    acc_next       = '0;
                    phase_next     = PH_FREQ;
                    tokens_next    = 3'd0;
                    in_record_next = 1'b0;
                end
                else
                begin
                    acc_next    = '0;
                    tokens_next = tokens_inc;
                end
            end
            default:
            begin
                phase_next = PH_HALT;
            end
        endcase
    end

    always_comb
    begin
        result.event_res   = EV_HALTED;
        result.field_value = '0;
        result.byte_echo   = '0;
        unique case (phase_reg)
            PH_FREQ, PH_TOKEN:
            begin
                priority if (end_in)
                begin
                    result.event_res = (in_record_reg || !groups_done) ?
                                       EV_TRUNCATED : EV_CLEAN_END;
                end
                else if (extra)
                begin
                    result.event_res = EV_EXTRA_BYTES;
                end
                else if (phase_reg == PH_FREQ)
                begin
                    result.byte_echo = byte_in;
                    priority if (freq_over)
                    begin
                        result.event_res = EV_FREQ_RANGE;
                    end
                    else if (cont)
                    begin
                        result.event_res = EV_MID;
                    end
                    else if (nxt_zero)
                    begin
                        result.event_res = (groups_inc == cfg.vocab_size) ?
                                           EV_ALL_GROUPS : EV_GROUP_END;
                    end
                    else
                    begin
                        result.event_res   = EV_FREQ_DONE;
                        result.field_value = 32'(nxt);
                    end
                end
                else
                begin
                    result.byte_echo = byte_in;
                    priority if (tok_over)
                    begin
                        result.event_res = EV_UNKNOWN_TOKEN;
                    end
                    else if (cont)
                    begin
                        result.event_res = EV_MID;
                    end
                    else
                    begin
                        result.event_res   = rec_done ? EV_RECORD_DONE : EV_TOKEN_DONE;
                        result.field_value = 32'(nxt);
                    end
                end
            end
            default:
            begin
                result.event_res = EV_HALTED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FREQ;
            acc_reg       <= '0;
            tokens_reg    <= '0;
            groups_reg    <= '0;
            in_record_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            tokens_reg    <= tokens_next;
            groups_reg    <= groups_next;
            in_record_reg <= in_record_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/nvrc_checker.sv -----
// ----------------------------------------------------------------------------
// nvrc_checker
// Port-level checks of the n-gram varint record checker, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module nvrc_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [nvrc_pkg::OUT_DATA_W-1:0]   m_tdata,
    input wire logic [nvrc_pkg::OUT_USER_W-1:0]   m_tuser
);
    import nvrc_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && (m_tuser == EV_HALTED)
        |=> !m_tvalid || (m_tuser == EV_HALTED))
        else $error("output left halted state without reset");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == EV_MID) || (m_tuser == EV_GROUP_END)
            || (m_tuser == EV_ALL_GROUPS) || (m_tuser == EV_CLEAN_END)
            || (m_tuser == EV_FREQ_RANGE) || (m_tuser == EV_UNKNOWN_TOKEN)
            || (m_tuser == EV_TRUNCATED) || (m_tuser == EV_EXTRA_BYTES)
            || (m_tuser == EV_HALTED))
        |-> (m_tdata[31:0] == 32'd0))
        else $error("field value nonzero on an event without a field");

    a_echo_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == EV_CLEAN_END) || (m_tuser == EV_TRUNCATED)
            || (m_tuser == EV_EXTRA_BYTES) || (m_tuser == EV_HALTED))
        |-> (m_tdata[39:32] == 8'd0))
        else $error("byte echo nonzero on an event without a byte");

endmodule

bind ngram_varint_record_checker nvrc_checker u_nvrc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- tb/varint_scoreboard_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_scoreboard_pkg
// Decode predictor and result store for the n-gram varint record checker.
// Tracks field phase, accumulated value, token and group counts, and queues
// the event each accepted input item should produce.
// ----------------------------------------------------------------------------

package varint_scoreboard_pkg;

    import nvrc_pkg::*;

    localparam int unsigned TOKEN_BITS = 32;

    class varint_scoreboard;

        logic [2:0]  tokens_cfg;
        logic [31:0] vocab;
        logic [14:0] fmax;

        phase_t      phase;
        logic [31:0] acc;
        logic [2:0]  tokens_done;
        logic [31:0] groups;
        bit          open;

        result_t     pending_events[$];
        int          fails;
        int          checked;

        function new();
            tokens_cfg  = 3'd1;
            vocab       = 32'd0;
            fmax        = 15'h7FFF;
            phase       = PH_FREQ;
            acc         = 32'd0;
            tokens_done = 3'd0;
            groups      = 32'd0;
            open        = 1'b0;
            fails       = 0;
            checked     = 0;
        endfunction

        function int outstanding();
            return pending_events.size();
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] v);
            case (idx)
                REG_TOKENS:   tokens_cfg = v[2:0];
                REG_VOCAB:    vocab      = v;
                REG_MAX_FREQ: fmax       = v[14:0];
                default:      ;
            endcase
        endfunction

        function int unsigned tokens_needed();
            int unsigned n;
            n = tokens_cfg;
            if (n == 0) n = 1;
            if (n > MAX_TOKENS) n = MAX_TOKENS;
            return n;
        endfunction

        function void predict_item(bit is_end, logic [7:0] b);
            result_t     r;
            logic [38:0] nxt;
            logic [63:0] lim;
            r.event_res   = EV_HALTED;
            r.field_value = 32'd0;
            r.byte_echo   = 8'd0;
            nxt = {acc, 7'd0} + {32'd0, b[6:0]};
            if (phase == PH_HALT) begin
            end else if (is_end) begin
                r.event_res = (open || groups < vocab) ? EV_TRUNCATED : EV_CLEAN_END;
                phase = PH_HALT;
            end else if (phase == PH_FREQ && !open && groups >= vocab) begin
                r.event_res = EV_EXTRA_BYTES;
                phase = PH_HALT;
            end else if (phase == PH_FREQ) begin
                r.byte_echo = b;
                if (nxt > {24'd0, fmax}) begin
                    r.event_res = EV_FREQ_RANGE;
                    phase = PH_HALT;
                end else if (b[7]) begin
                    acc  = nxt[31:0];
                    open = 1'b1;
                    r.event_res = EV_MID;
                end else if (nxt == 39'd0) begin
                    acc    = 32'd0;
                    open   = 1'b0;
                    groups = groups + 32'd1;
                    r.event_res = (groups == vocab) ? EV_ALL_GROUPS : EV_GROUP_END;
                end else begin
                    acc         = 32'd0;
                    phase       = PH_TOKEN;
                    tokens_done = 3'd0;
                    open        = 1'b1;
                    r.event_res   = EV_FREQ_DONE;
                    r.field_value = nxt[31:0];
                end
            end else begin
                r.byte_echo = b;
                lim = {32'd0, vocab};
                if ((64'd1 << TOKEN_BITS) < lim) lim = 64'd1 << TOKEN_BITS;
                if ({25'd0, nxt} >= lim) begin
                    r.event_res = EV_UNKNOWN_TOKEN;
                    phase = PH_HALT;
                end else if (b[7]) begin
                    acc = nxt[31:0];
                    r.event_res = EV_MID;
                end else begin
                    acc         = 32'd0;
                    tokens_done = tokens_done + 3'd1;
                    r.field_value = nxt[31:0];
                    if (tokens_done >= tokens_needed()) begin
                        phase       = PH_FREQ;
                        tokens_done = 3'd0;
                        open        = 1'b0;
                        r.event_res = EV_RECORD_DONE;
                    end else begin
                        r.event_res = EV_TOKEN_DONE;
                    end
                end
            end
            pending_events.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            fails++;
        endtask

        task check_event(result_t got);
            result_t want;
            if (pending_events.size() == 0) begin
                report($sformatf("unexpected result, event %0d", got.event_res));
            end else begin
                want = pending_events.pop_front();
                checked++;
                if (got.event_res !== want.event_res)
                    report($sformatf("result %0d event %0d, want %0d",
                                     checked, got.event_res, want.event_res));
                if (got.field_value !== want.field_value)
                    report($sformatf("result %0d value %0h, want %0h",
                                     checked, got.field_value, want.field_value));
                if (got.byte_echo !== want.byte_echo)
                    report($sformatf("result %0d byte %0h, want %0h",
                                     checked, got.byte_echo, want.byte_echo));
            end
        endtask

    endclass

endpackage

// ----- tb/ngram_varint_record_checker_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngram_varint_record_checker_test
// Streams varint-coded n-gram records through the checker under random
// source gaps and sink stalls, and compares every result item against a
// decode predictor. The stream runs through several register settings and
// is closed by one randomly chosen terminal condition.
// ----------------------------------------------------------------------------

module ngram_varint_record_checker_test;

    import nvrc_pkg::*;
    import varint_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 600;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        cfg_we   = 1'b0;
    logic [1:0]  cfg_addr = 2'd0;
    logic [31:0] cfg_data = 32'd0;

    varint_scoreboard sb = new();

    int    items_sent  = 0;
    int    cfg_writes  = 0;
    int    cycles      = 0;
    bit    steady      = 1'b0;
    string closing     = "";

    ngram_varint_record_checker i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.event_res   = evt_t'(m_tuser);
            got.field_value = m_tdata[31:0];
            got.byte_echo   = m_tdata[39:32];
            sb.check_event(got);
        end
        m_tready <= steady || ($urandom_range(0, 99) >= 20);
    end

    task send_item(input bit is_end, input logic [7:0] b);
        if (!steady && $urandom_range(0, 99) < 20)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= is_end;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.predict_item(is_end, b);
        items_sent++;
        steady = (items_sent >= 250 && items_sent < 400);
    endtask

    // big-endian 7-bit groups, optional leading zero groups
    task send_field(input logic [31:0] v, input int pad);
        int n;
        logic [7:0] b;
        n = 1;
        while (n < 5 && (v >> (7 * n)) != 0) n++;
        repeat (pad) send_item(1'b0, 8'h80);
        for (int i = n - 1; i >= 0; i--)
        begin
            b = {(i != 0), 7'((v >> (7 * i)) & 32'h7F)};
            send_item(1'b0, b);
        end
    endtask

    task write_reg(input reg_idx_t idx, input logic [31:0] v);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= v;
        @(posedge clk);
        sb.set_reg(idx, v);
        cfg_we <= 1'b0;
        @(posedge clk);
        cfg_writes++;
    endtask

    task drain();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function logic [31:0] pick_token();
        logic [31:0] t;
        int unsigned off;
        case ($urandom_range(0, 3))
            0: t = $urandom_range(0, 127);
            1:
            begin
                off = $urandom_range(0, 3);
                t = (sb.vocab > off) ? sb.vocab - 1 - off : 32'd0;
            end
            2: t = $urandom >> $urandom_range(0, 31);
            default: t = $urandom;
        endcase
        if (t >= sb.vocab) t = t % sb.vocab;
        return t;
    endfunction

    function logic [31:0] pick_freq();
        case ($urandom_range(0, 3))
            0: return 32'd1;
            1: return {17'd0, sb.fmax};
            default: return $urandom_range(1, sb.fmax);
        endcase
    endfunction

    function int pick_pad();
        return ($urandom_range(0, 99) < 15) ? $urandom_range(1, 2) : 0;
    endfunction

    task send_record();
        int unsigned n;
        n = sb.tokens_needed();
        send_field(pick_freq(), pick_pad());
        repeat (n) send_field(pick_token(), pick_pad());
    endtask

    task send_group_end();
        send_field(32'd0, pick_pad());
    endtask

    initial
    begin
        int units;
        logic [31:0] v;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: extreme fields, padding, group ends, token count extremes
        write_reg(REG_TOKENS, 32'd0);
        write_reg(REG_VOCAB, 32'hFFFF_FFFF);
        write_reg(REG_MAX_FREQ, 32'd32767);
        send_field(32'd32767, 0);
        send_field(32'hFFFF_FFFE, 0);
        send_group_end();
        send_field(32'd0, 1);
        send_field(32'd1, 0);
        send_field(32'd0, 0);
        drain();
        write_reg(REG_MAX_FREQ, 32'd0);
        send_field(32'd0, 2);
        drain();
        write_reg(REG_TOKENS, 32'd7);
        write_reg(REG_MAX_FREQ, 32'd32767);
        send_field(32'd2, 0);
        send_field(32'd0, 0);
        send_field(32'd127, 0);
        send_field(32'd128, 0);
        send_field(32'hFFFF_FFFE, 0);
        repeat (3) send_field($urandom_range(0, 15), 0);
        drain();

        // random phases
        while (items_sent < ITEM_TARGET)
        begin
            write_reg(REG_TOKENS, $urandom_range(0, 7));
            case ($urandom_range(0, 3))
                0: v = 32'hFFFF_FFFF;
                1: v = sb.groups + $urandom_range(1, 4);
                2: v = sb.groups + $urandom_range(5, 300);
                default: v = $urandom;
            endcase
            if (v <= sb.groups) v = 32'hFFFF_FFFF;
            write_reg(REG_VOCAB, v);
            case ($urandom_range(0, 4))
                0: v = 32'd0;
                1: v = 32'd32767;
                2: v = $urandom_range(1, 127);
                default: v = $urandom_range(0, 32767);
            endcase
            write_reg(REG_MAX_FREQ, v);
            units = $urandom_range(5, 20);
            for (int u = 0; u < units; u++)
            begin
                if (sb.groups >= sb.vocab || items_sent >= ITEM_TARGET) break;
                if (sb.fmax == 0 || $urandom_range(0, 99) < 15)
                    send_group_end();
                else
                    send_record();
            end
            drain();
        end

        // close the stream with one terminal condition
        case ($urandom_range(0, 4))
            0:
            begin
                closing = "clean end";
                write_reg(REG_VOCAB, sb.groups);
                send_item(1'b1, 8'($urandom));
            end
            1:
            begin
                closing = "truncated record";
                write_reg(REG_VOCAB, 32'hFFFF_FFFF);
                send_field(32'd3, 0);
                send_item(1'b0, 8'h81);
                send_item(1'b1, 8'($urandom));
            end
            2:
            begin
                closing = "extra bytes";
                write_reg(REG_VOCAB, sb.groups);
                send_item(1'b0, 8'($urandom));
            end
            3:
            begin
                closing = "frequency over limit";
                write_reg(REG_MAX_FREQ, $urandom_range(0, 300));
                send_field({17'd0, sb.fmax} + 32'd1, pick_pad());
            end
            default:
            begin
                closing = "unknown token";
                write_reg(REG_VOCAB, sb.groups + $urandom_range(1, 1000));
                send_field(32'd1, 0);
                send_field(32'hFFFF_FFFF, 0);
            end
        endcase
        repeat (8) send_item($urandom_range(0, 1), 8'($urandom));

        drain();
        repeat (20) @(posedge clk);
        if (sb.outstanding() != 0)
            sb.report($sformatf("%0d results never arrived", sb.outstanding()));

        $display("covered %0d items, %0d results, %0d groups, %0d register writes",
                 items_sent, sb.checked, sb.groups, cfg_writes);
        $display("stream closed by %s, then fed while halted", closing);
        if (sb.fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/nvrc_pkg.sv
sv/nvrc_core.sv
sv/ngram_varint_record_checker.sv
sv/nvrc_checker.sv
tb/varint_scoreboard_pkg.sv
tb/ngram_varint_record_checker_test.sv
